### sv/qxm_pkg.sv
package qxm_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned AmtW  = 15;
  localparam int unsigned IntW  = 24;
  localparam int unsigned NumMotors = 4;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic signed [IntW-1:0]  wide_t;
  typedef logic        [AmtW-1:0]  amt_t;

  typedef enum logic [1:0] {
    CfgOutputMin     = 2'd0,
    CfgOutputMax     = 2'd1,
    CfgClampEnable   = 2'd2,
    CfgYawDesatEnable = 2'd3
  } cfg_idx_e;

  localparam wide_t DataMax = wide_t'(32767);
  localparam wide_t DataMin = -wide_t'(32768);
  localparam wide_t AmtMax  = wide_t'(32767);

  function automatic data_t sat_data(wide_t v);
    data_t r;
    if (v > DataMax) begin
      r = data_t'(DataMax);
    end else if (v < DataMin) begin
      r = data_t'(DataMin);
    end else begin
      r = data_t'(v);
    end
    return r;
  endfunction

  function automatic wide_t wmin(wide_t a, wide_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic wide_t wmax(wide_t a, wide_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

### sv/qxm_if.sv
interface qxm_cmd_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  throttle_cmd;
  logic signed [15:0]  roll_cmd;
  logic signed [15:0]  pitch_cmd;
  logic signed [15:0]  yaw_cmd;

  modport source (output valid, output throttle_cmd, output roll_cmd, output pitch_cmd,
                  output yaw_cmd, input ready);
  modport sink (input valid, input throttle_cmd, input roll_cmd, input pitch_cmd,
                input yaw_cmd, output ready);
endinterface

interface qxm_res_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  rear_right_out;
  logic signed [15:0]  fore_right_out;
  logic signed [15:0]  rear_left_out;
  logic signed [15:0]  fore_left_out;
  logic signed [15:0]  throttle_out;
  logic        [14:0]  overshoot_amt;
  logic signed [15:0]  undershoot_amt;

  modport source (output valid, output rear_right_out, output fore_right_out,
                  output rear_left_out, output fore_left_out, output throttle_out,
                  output overshoot_amt, output undershoot_amt, input ready);
  modport sink (input valid, input rear_right_out, input fore_right_out,
                input rear_left_out, input fore_left_out, input throttle_out,
                input overshoot_amt, input undershoot_amt, output ready);
endinterface

### sv/qxm_desat.sv
module qxm_desat (
  input  qxm_pkg::wide_t m_i [qxm_pkg::NumMotors],
  input  qxm_pkg::wide_t yaw_i,
  input  qxm_pkg::wide_t out_min_i,
  input  qxm_pkg::wide_t out_max_i,
  input  logic           desat_en_i,
  output qxm_pkg::wide_t under_o,
  output qxm_pkg::wide_t over_o
);

  logic           yaw_pos;
  logic           active;
  qxm_pkg::wide_t ag0, ag1, wt0, wt1;

  always_comb begin
    yaw_pos = (yaw_i > qxm_pkg::wide_t'(0));
    active  = desat_en_i && (yaw_i != qxm_pkg::wide_t'(0));
    if (yaw_pos) begin
      ag0 = m_i[1];
      ag1 = m_i[2];
      wt0 = m_i[0];
      wt1 = m_i[3];
    end else begin
      ag0 = m_i[0];
      ag1 = m_i[3];
      wt0 = m_i[1];
      wt1 = m_i[2];
    end
    if (active) begin
      under_o = qxm_pkg::wmin(qxm_pkg::wmin(qxm_pkg::wide_t'(0), ag0 - out_min_i),
                              ag1 - out_min_i);
      over_o  = qxm_pkg::wmax(qxm_pkg::wmax(qxm_pkg::wide_t'(0), wt0 - out_max_i),
                              wt1 - out_max_i);
    end else begin
      under_o = qxm_pkg::wide_t'(0);
      over_o  = qxm_pkg::wide_t'(0);
    end
  end

endmodule

### sv/quad_x_motor_mixer_desat.sv
// Channel   Dir  Fields
// cmd_i     in   throttle_cmd, roll_cmd, pitch_cmd, yaw_cmd
// res_o     out  four motor outputs, throttle_out, overshoot_amt, undershoot_amt
// cfg_*_i   in   output_min, output_max, clamp_enable, yaw_desat_enable
//
// A command beat passes through the four-stage register pipeline to its result beat, and
// one beat can enter every cycle while the result side does not stall the pipeline.
// Reset clears the stage valid bits and loads the register defaults.
// When the result is not taken, the whole pipeline holds and no beat is lost.
module quad_x_motor_mixer_desat (
  input  logic              clk_i,
  input  logic              rst_ni,
  qxm_cmd_if.sink           cmd_i,
  qxm_res_if.source         res_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i
);

  localparam int unsigned N = qxm_pkg::NumMotors;

  qxm_pkg::data_t out_min_q, out_max_q;
  logic           clamp_en_q, desat_en_q;
  qxm_pkg::wide_t out_min_w, out_max_w;

  logic advance;

  logic           s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  qxm_pkg::wide_t s1_m_q [N];
  qxm_pkg::wide_t s1_m_d [N];
  qxm_pkg::wide_t s1_thr_q, s1_yaw_q;
  qxm_pkg::wide_t s2_m_q [N];
  qxm_pkg::wide_t s2_m_d [N];
  qxm_pkg::wide_t s2_thr_q, s2_yaw_q;
  qxm_pkg::wide_t s3_m_q [N];
  qxm_pkg::wide_t s3_thr_q, s3_yaw_q, s3_under_q, s3_over_q;
  qxm_pkg::wide_t s3_under_d, s3_over_d;

  qxm_pkg::wide_t fin_m [N];
  qxm_pkg::wide_t fin_thr, sum, delta;
  logic           apply;

  qxm_pkg::data_t br_q, fr_q, bl_q, fl_q, thr_out_q, under_out_q;
  qxm_pkg::amt_t  over_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_min_q  <= qxm_pkg::data_t'(0);
      out_max_q  <= qxm_pkg::data_t'(4096);
      clamp_en_q <= 1'b1;
      desat_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (qxm_pkg::cfg_idx_e'(cfg_idx_i))
        qxm_pkg::CfgOutputMin:      out_min_q  <= cfg_wdata_i;
        qxm_pkg::CfgOutputMax:      out_max_q  <= cfg_wdata_i;
        qxm_pkg::CfgClampEnable:    clamp_en_q <= cfg_wdata_i[0];
        qxm_pkg::CfgYawDesatEnable: desat_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign out_min_w = qxm_pkg::wide_t'(out_min_q);
  assign out_max_w = qxm_pkg::wide_t'(out_max_q);

  assign advance     = !s4_valid_q || res_o.ready;
  assign cmd_i.ready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= cmd_i.valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  // Stage 1: roll/pitch mix.
  always_comb begin
    qxm_pkg::wide_t t, r, p;
    t = qxm_pkg::wide_t'(cmd_i.throttle_cmd);
    r = qxm_pkg::wide_t'(cmd_i.roll_cmd);
    p = qxm_pkg::wide_t'(cmd_i.pitch_cmd);
    s1_m_d[0] = t - r - p;
    s1_m_d[1] = t - r + p;
    s1_m_d[2] = t + r - p;
    s1_m_d[3] = t + r + p;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_m_q   <= s1_m_d;
      s1_thr_q <= qxm_pkg::wide_t'(cmd_i.throttle_cmd);
      s1_yaw_q <= qxm_pkg::wide_t'(cmd_i.yaw_cmd);
    end
  end

  // Stage 2: optional clamp, then yaw with the alternating sign pattern.
  always_comb begin
    qxm_pkg::wide_t c;
    for (int i = 0; i < N; i++) begin
      c = s1_m_q[i];
      if (clamp_en_q) begin
        priority if (s1_m_q[i] < out_min_w) begin
          c = out_min_w;
        end else if (s1_m_q[i] > out_max_w) begin
          c = out_max_w;
        end else begin
          c = s1_m_q[i];
        end
      end
      if (i == 0 || i == 3) begin
        s2_m_d[i] = c + s1_yaw_q;
      end else begin
        s2_m_d[i] = c - s1_yaw_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_m_q   <= s2_m_d;
      s2_thr_q <= s1_thr_q;
      s2_yaw_q <= s1_yaw_q;
    end
  end

  // Stage 3: undershoot and overshoot search.
  qxm_desat u_desat (
    .m_i        (s2_m_q),
    .yaw_i      (s2_yaw_q),
    .out_min_i  (out_min_w),
    .out_max_i  (out_max_w),
    .desat_en_i (desat_en_q),
    .under_o    (s3_under_d),
    .over_o     (s3_over_d)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s3_m_q     <= s2_m_q;
      s3_thr_q   <= s2_thr_q;
      s3_yaw_q   <= s2_yaw_q;
      s3_under_q <= s3_under_d;
      s3_over_q  <= s3_over_d;
    end
  end

  // Stage 4: apply the yaw cut when the reduced yaw keeps its sign.
  always_comb begin
    sum = s3_yaw_q + s3_under_q - s3_over_q;
    if (s3_yaw_q > qxm_pkg::wide_t'(0)) begin
      apply = (sum > qxm_pkg::wide_t'(0));
      delta = s3_under_q - s3_over_q;
    end else begin
      apply = (s3_yaw_q - s3_under_q + s3_over_q) < qxm_pkg::wide_t'(0);
      delta = s3_over_q - s3_under_q;
    end
    if (!apply) begin
      delta = qxm_pkg::wide_t'(0);
    end
    fin_m[0] = s3_m_q[0] + delta;
    fin_m[1] = s3_m_q[1] - delta;
    fin_m[2] = s3_m_q[2] - delta;
    fin_m[3] = s3_m_q[3] + delta;
    fin_thr  = apply ? (s3_thr_q - (s3_under_q + s3_over_q)) : s3_thr_q;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      br_q      <= qxm_pkg::sat_data(fin_m[0]);
      fr_q      <= qxm_pkg::sat_data(fin_m[1]);
      bl_q      <= qxm_pkg::sat_data(fin_m[2]);
      fl_q      <= qxm_pkg::sat_data(fin_m[3]);
      thr_out_q <= qxm_pkg::sat_data(fin_thr);
      over_out_q <= (s3_over_q > qxm_pkg::AmtMax) ? qxm_pkg::amt_t'(qxm_pkg::AmtMax)
                                                  : qxm_pkg::amt_t'(s3_over_q);
      under_out_q <= qxm_pkg::sat_data(s3_under_q);
    end
  end

  assign res_o.valid          = s4_valid_q;
  assign res_o.rear_right_out = br_q;
  assign res_o.fore_right_out = fr_q;
  assign res_o.rear_left_out  = bl_q;
  assign res_o.fore_left_out  = fl_q;
  assign res_o.throttle_out   = thr_out_q;
  assign res_o.overshoot_amt  = over_out_q;
  assign res_o.undershoot_amt = under_out_q;

endmodule
